[hw/rtl/seven_segment_frame_serializer_core_macros.svh]
// Assertion macros for the seven-segment frame serializer.
// Both forms take a label, clock, reset, antecedent, consequent and message.
`ifndef SEVEN_SEGMENT_FRAME_SERIALIZER_CORE_MACROS_SVH
`define SEVEN_SEGMENT_FRAME_SERIALIZER_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SSSF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define SSSF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SSSF_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SSSF_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[hw/rtl/sssf_pkg.sv]
`timescale 1ns / 1ps

package sssf_pkg;

   // Width of the bit position carried on each result beat.
   localparam int unsigned INDEX_W = 5;

   // Reciprocal of ten in 0.19 fixed point; exact for every 16-bit value.
   localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
   localparam int unsigned DIV10_SHIFT = 19;

   // One result beat: frame bit, its position and the latch request.
   typedef struct packed {
      logic                 latch_after;
      logic [INDEX_W-1:0]   bit_index;
      logic                 serial_bit;
   } rsp_beat_type;

   // Quotient of a 16-bit value by ten.
   function automatic logic [12:0] div10(input logic [15:0] x);
      logic [31:0] prod;
      begin
         prod = 32'(x) * 32'(DIV10_MUL);
         return prod[31:DIV10_SHIFT];
      end
   endfunction

   // Remainder by ten, given the quotient; ten times q is built from shifts.
   function automatic logic [3:0] rem10(input logic [15:0] x, input logic [15:0] q);
      logic [15:0] diff;
      begin
         diff = x - (q << 3) - (q << 1);
         return diff[3:0];
      end
   endfunction

   // Segments for the hundreds (upper half) and units displays.
   function automatic logic [15:0] outer_seg(input logic [3:0] d);
      logic [15:0] seg;
      begin
         unique case (d)
            4'd0:    seg = 16'h7007;
            4'd1:    seg = 16'h4001;
            4'd2:    seg = 16'h300B;
            4'd3:    seg = 16'h600B;
            4'd4:    seg = 16'h400D;
            4'd5:    seg = 16'h600E;
            4'd6:    seg = 16'h700E;
            4'd7:    seg = 16'h4003;
            4'd8:    seg = 16'h700F;
            4'd9:    seg = 16'h600F;
            default: seg = 16'h0000;
         endcase
         return seg;
      end
   endfunction

   // Segments for the tens display.
   function automatic logic [15:0] middle_seg(input logic [3:0] d);
      logic [15:0] seg;
      begin
         unique case (d)
            4'd0:    seg = 16'h0770;
            4'd1:    seg = 16'h0410;
            4'd2:    seg = 16'h03B0;
            4'd3:    seg = 16'h06B0;
            4'd4:    seg = 16'h04D0;
            4'd5:    seg = 16'h06E0;
            4'd6:    seg = 16'h07E0;
            4'd7:    seg = 16'h0430;
            4'd8:    seg = 16'h07F0;
            4'd9:    seg = 16'h06F0;
            default: seg = 16'h0000;
         endcase
         return seg;
      end
   endfunction

   // LED bar pattern; a count above eight lights nothing.
   function automatic logic [15:0] bar_seg(input logic [3:0] n);
      logic [15:0] seg;
      begin
         unique case (n)
            4'd0:    seg = 16'h0000;
            4'd1:    seg = 16'h0100;
            4'd2:    seg = 16'h0300;
            4'd3:    seg = 16'h0700;
            4'd4:    seg = 16'h0F00;
            4'd5:    seg = 16'h0F80;
            4'd6:    seg = 16'h0FC0;
            4'd7:    seg = 16'h0FE0;
            4'd8:    seg = 16'h0FF0;
            default: seg = 16'h0000;
         endcase
         return seg;
      end
   endfunction

   // Decimal-point mask for the selected display.
   function automatic logic [31:0] point_mask(input logic [1:0] p);
      logic [31:0] mask;
      begin
         unique case (p)
            2'd0:    mask = 32'h0000_0000;
            2'd1:    mask = 32'h0000_8000;
            2'd2:    mask = 32'h0000_0800;
            default: mask = 32'h8000_0000;
         endcase
         return mask;
      end
   endfunction

   // Full 32-bit display frame from the three digits, bar count and point.
   function automatic logic [31:0] compose(input logic [3:0] hundreds,
                                           input logic [3:0] tens,
                                           input logic [3:0] units,
                                           input logic [3:0] leds,
                                           input logic [1:0] dot);
      logic [31:0] frame;
      begin
         frame = {outer_seg(hundreds) | bar_seg(leds), 16'h0000};
         frame = frame | {16'h0000, middle_seg(tens) | outer_seg(units)};
         frame = frame | point_mask(dot);
         return frame;
      end
   endfunction

endpackage

[hw/rtl/sssf_front.sv]
`timescale 1ns / 1ps

module sssf_front #(
   parameter int unsigned FRAME_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [15:0]           req_value,
   input  logic [3:0]            req_led_count,
   input  logic [1:0]            req_point_sel,
   input  logic [31:0]           req_raw_word,
   output logic                  push_valid,
   input  logic                  push_ready,
   output logic [FRAME_BITS-1:0] push_frame
);

   // Stage valid bits.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic pipe_adv;

   // Fields that ride along all stages.
   logic        s1_func_ff, s2_func_ff, s3_func_ff, s4_func_ff;
   logic [3:0]  s1_led_ff,  s2_led_ff,  s3_led_ff,  s4_led_ff;
   logic [1:0]  s1_dot_ff,  s2_dot_ff,  s3_dot_ff,  s4_dot_ff;
   logic [31:0] s1_raw_ff,  s2_raw_ff,  s3_raw_ff,  s4_raw_ff;

   // Digit extraction values.
   logic [15:0] s1_value_ff, s2_value_ff;
   logic [12:0] s2_q1_ff, s3_q1_ff;
   logic [9:0]  s3_q2_ff, s4_q2_ff;
   logic [6:0]  s4_q3_ff;
   logic [3:0]  s3_units_ff, s4_units_ff;
   logic [3:0]  s4_tens_ff;

   // Next values of the digit registers.
   logic [12:0] s2_q1_in;
   logic [9:0]  s3_q2_in;
   logic [6:0]  s4_q3_in;
   logic [3:0]  s3_units_in, s4_tens_in, hundreds;
   logic [31:0] composed;

   // The whole pipeline moves together whenever its last stage can drain.
   assign pipe_adv  = !s4_valid_ff || push_ready;
   assign req_ready = pipe_adv && !reset;

   // One division by ten per stage, each product registered before the next.
   always_comb begin
      s2_q1_in    = sssf_pkg::div10(s1_value_ff);
      s3_units_in = sssf_pkg::rem10(s2_value_ff, 16'(s2_q1_ff));
      s3_q2_in    = 10'(sssf_pkg::div10(16'(s2_q1_ff)));
      s4_tens_in  = sssf_pkg::rem10(16'(s3_q1_ff), 16'(s3_q2_ff));
      s4_q3_in    = 7'(sssf_pkg::div10(16'(s3_q2_ff)));
      hundreds    = sssf_pkg::rem10(16'(s4_q2_ff), 16'(s4_q3_ff));
      composed    = sssf_pkg::compose(hundreds, s4_tens_ff, s4_units_ff,
                                      s4_led_ff, s4_dot_ff);
   end

   // Frame selection at the last stage.
   assign push_valid = s4_valid_ff;
   assign push_frame = s4_func_ff ? FRAME_BITS'(s4_raw_ff) : FRAME_BITS'(composed);

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (pipe_adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         s1_func_ff  <= req_func;
         s1_value_ff <= req_value;
         s1_led_ff   <= req_led_count;
         s1_dot_ff   <= req_point_sel;
         s1_raw_ff   <= req_raw_word;

         s2_func_ff  <= s1_func_ff;
         s2_value_ff <= s1_value_ff;
         s2_q1_ff    <= s2_q1_in;
         s2_led_ff   <= s1_led_ff;
         s2_dot_ff   <= s1_dot_ff;
         s2_raw_ff   <= s1_raw_ff;

         s3_func_ff  <= s2_func_ff;
         s3_q1_ff    <= s2_q1_ff;
         s3_q2_ff    <= s3_q2_in;
         s3_units_ff <= s3_units_in;
         s3_led_ff   <= s2_led_ff;
         s3_dot_ff   <= s2_dot_ff;
         s3_raw_ff   <= s2_raw_ff;

         s4_func_ff  <= s3_func_ff;
         s4_q2_ff    <= s3_q2_ff;
         s4_q3_ff    <= s4_q3_in;
         s4_tens_ff  <= s4_tens_in;
         s4_units_ff <= s3_units_ff;
         s4_led_ff   <= s3_led_ff;
         s4_dot_ff   <= s3_dot_ff;
         s4_raw_ff   <= s3_raw_ff;
      end
   end

endmodule

[hw/rtl/sssf_queue.sv]
`timescale 1ns / 1ps

module sssf_queue #(
   parameter int unsigned FRAME_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  logic [FRAME_BITS-1:0] push_frame,
   output logic                  pop_valid,
   input  logic                  pop,
   output logic [FRAME_BITS-1:0] pop_frame
);

   localparam logic [1:0] DEPTH = 2'd2;

   logic [FRAME_BITS-1:0] head_ff, head_in;
   logic [FRAME_BITS-1:0] tail_ff, tail_in;
   logic [1:0]            count_ff, count_in;
   logic [1:0]            slot;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != DEPTH);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_frame  = head_ff;

   // Two-entry queue: the head is always the oldest frame.
   always_comb begin
      do_push  = push_valid && push_ready;
      do_pop   = pop && pop_valid;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
      slot     = count_ff - 2'(do_pop);
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (do_pop) begin
         head_in = tail_ff;
      end
      if (do_push) begin
         if (slot == 2'd0) begin
            head_in = push_frame;
         end else begin
            tail_in = push_frame;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

[hw/rtl/sssf_back.sv]
`timescale 1ns / 1ps

module sssf_back #(
   parameter int unsigned FRAME_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   frame_valid,
   input  logic [FRAME_BITS-1:0]  frame_data,
   output logic                   frame_pop,
   output logic                   beat_valid,
   input  logic                   beat_ready,
   output sssf_pkg::rsp_beat_type beat
);

   localparam int unsigned CNT_W = $clog2(FRAME_BITS);

   logic                   active_ff, active_in;
   logic [FRAME_BITS-1:0]  shift_ff, shift_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   out_valid_ff, out_valid_in;
   sssf_pkg::rsp_beat_type beat_ff, beat_in;
   logic                   out_adv, last_bit;

   assign beat_valid = out_valid_ff;
   assign beat       = beat_ff;

   // Load a frame, then shift one bit per cycle into the output register while the output is not stalled.
   always_comb begin
      out_adv      = !out_valid_ff || beat_ready;
      last_bit     = (cnt_ff == CNT_W'(FRAME_BITS - 1));
      active_in    = active_ff;
      shift_in     = shift_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      beat_in      = beat_ff;
      frame_pop    = 1'b0;
      if (!active_ff) begin
         if (frame_valid) begin
            frame_pop = 1'b1;
            active_in = 1'b1;
            shift_in  = frame_data;
            cnt_in    = '0;
         end
         if (out_adv) begin
            out_valid_in = 1'b0;
         end
      end else if (out_adv) begin
         out_valid_in        = 1'b1;
         beat_in.serial_bit  = shift_ff[0];
         beat_in.bit_index   = sssf_pkg::INDEX_W'(cnt_ff);
         beat_in.latch_after = last_bit;
         shift_in            = shift_ff >> 1;
         cnt_in              = cnt_ff + CNT_W'(1);
         if (last_bit) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      cnt_ff   <= cnt_in;
      beat_ff  <= beat_in;
   end

endmodule

[hw/rtl/seven_segment_frame_serializer_core.sv]
`timescale 1ns / 1ps
// Seven-segment frame serializer.
// The req channel takes one beat per frame. With tuser low the frame is
// built from the low three decimal digits of value, the LED bar count and
// the decimal-point position; with tuser high raw_word is the frame.
// The rsp channel gives one beat per frame bit, least significant first,
// with the bit position in tdata and tlast on the final bit, which is the
// moment to pulse the display latch.
// An accepted req beat passes front stages s1 to s4, the queue and the
// serializer's load before its first rsp beat is registered. The
// serializer shifts out one bit per cycle while rsp is not stalled, then
// loads the next frame from its queue, so that loop sets the sustained rate.
// A four-stage digit pipeline and a two-frame queue sit ahead of the
// serializer, so up to six more req beats are taken while a frame shifts.
// Reset clears all valid state; nothing in flight survives it.
// A stall on rsp holds the current beat; the queue then fills and req_tready
// drops until space returns.
`include "seven_segment_frame_serializer_core_macros.svh"

module seven_segment_frame_serializer_core #(
   parameter int unsigned FRAME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // value[15:0], led_count[19:16], point_sel[21:20], raw_word[53:22], zero[55:54]
   input  logic [55:0] req_tdata,
   // func[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // serial_bit[0], bit_index[5:1], zero[7:6]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   logic                   push_valid, push_ready;
   logic [FRAME_BITS-1:0]  push_frame;
   logic                   pop_valid, pop;
   logic [FRAME_BITS-1:0]  pop_frame;
   sssf_pkg::rsp_beat_type beat;

   // Front end: digit extraction and frame composition.
   sssf_front #(
      .FRAME_BITS (FRAME_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_func      (req_tuser),
      .req_value     (req_tdata[15:0]),
      .req_led_count (req_tdata[19:16]),
      .req_point_sel (req_tdata[21:20]),
      .req_raw_word  (req_tdata[53:22]),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_frame    (push_frame)
   );

   // Frame queue between the two halves.
   sssf_queue #(
      .FRAME_BITS (FRAME_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_frame (push_frame),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_frame  (pop_frame)
   );

   // Back end: bit serializer.
   sssf_back #(
      .FRAME_BITS (FRAME_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (pop_valid),
      .frame_data  (pop_frame),
      .frame_pop   (pop),
      .beat_valid  (rsp_tvalid),
      .beat_ready  (rsp_tready),
      .beat        (beat)
   );

   // Output packing.
   assign rsp_tdata = {2'b00, beat.bit_index, beat.serial_bit};
   assign rsp_tlast = beat.latch_after;

   // The latch request only comes with the last bit position of a frame.
   `SSSF_ASSERT_IMP(a_last_index, clock, reset, rsp_tvalid && rsp_tlast,
      rsp_tdata[5:1] == 5'(FRAME_BITS - 1), "latch request on a bit other than the last")
   // Inside a frame the next bit is ready right after a beat is taken.
   `SSSF_ASSERT_NXT(a_no_gap, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast,
      rsp_tvalid, "gap inside a frame")
   // Bit positions step by one inside a frame.
   `SSSF_ASSERT_NXT(a_index_step, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast,
      rsp_tdata[5:1] == $past(rsp_tdata[5:1]) + 5'd1, "bit position did not advance by one")

endmodule

[sim/tb_seven_segment_frame_serializer_core.sv]
`timescale 1ns / 1ps

module tb_seven_segment_frame_serializer_core;

   // Frame source selected by req_tuser.
   localparam bit FUNC_COMPOSE = 1'b0;
   localparam bit FUNC_RAW     = 1'b1;

   localparam int FRAME_LEN      = 32;
   localparam int RANDOM_FRAMES  = 470;
   localparam int QUIET_FRAMES   = 80;
   localparam int SETTLE_CYCLES  = 80;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   // Random idling on both channels is allowed only while this is set.
   bit gaps_on;

   // Expected serial beats for every accepted frame, checked in order.
   class frame_scoreboard;
      sssf_pkg::rsp_beat_type bit_queue[$];
      int                     failures;
      int                     beats_seen;

      function bit [15:0] outer_segments(int d);
         case (d)
            0:       return 16'h7007;
            1:       return 16'h4001;
            2:       return 16'h300B;
            3:       return 16'h600B;
            4:       return 16'h400D;
            5:       return 16'h600E;
            6:       return 16'h700E;
            7:       return 16'h4003;
            8:       return 16'h700F;
            default: return 16'h600F;
         endcase
      endfunction

      // Display frame for one request beat.
      function bit [31:0] display_frame(bit func, bit [15:0] value, bit [3:0] leds,
                                        bit [1:0] dot, bit [31:0] raw);
         bit [15:0] upper;
         bit [15:0] lower;
         bit [15:0] tens_seg;
         bit [15:0] bar;
         bit [31:0] point;
         int        num;
         if (func == FUNC_RAW) return raw;
         num = int'(value);
         case ((num / 10) % 10)
            0:       tens_seg = 16'h0770;
            1:       tens_seg = 16'h0410;
            2:       tens_seg = 16'h03B0;
            3:       tens_seg = 16'h06B0;
            4:       tens_seg = 16'h04D0;
            5:       tens_seg = 16'h06E0;
            6:       tens_seg = 16'h07E0;
            7:       tens_seg = 16'h0430;
            8:       tens_seg = 16'h07F0;
            default: tens_seg = 16'h06F0;
         endcase
         // A bar count above eight lights nothing.
         case (leds)
            4'd1:    bar = 16'h0100;
            4'd2:    bar = 16'h0300;
            4'd3:    bar = 16'h0700;
            4'd4:    bar = 16'h0F00;
            4'd5:    bar = 16'h0F80;
            4'd6:    bar = 16'h0FC0;
            4'd7:    bar = 16'h0FE0;
            4'd8:    bar = 16'h0FF0;
            default: bar = 16'h0000;
         endcase
         case (dot)
            2'd0:    point = 32'h0000_0000;
            2'd1:    point = 32'h0000_8000;
            2'd2:    point = 32'h0000_0800;
            default: point = 32'h8000_0000;
         endcase
         upper = outer_segments((num / 100) % 10) | bar;
         lower = tens_seg | outer_segments(num % 10);
         return {upper, lower} | point;
      endfunction

      // An accepted request beat yields one result beat per frame bit.
      function void note_frame(bit func, bit [15:0] value, bit [3:0] leds,
                               bit [1:0] dot, bit [31:0] raw);
         bit [31:0]              frame;
         sssf_pkg::rsp_beat_type beat;
         frame = display_frame(func, value, leds, dot, raw);
         for (int k = 0; k < FRAME_LEN; k++) begin
            beat.serial_bit  = frame[k];
            beat.bit_index   = k[sssf_pkg::INDEX_W-1:0];
            beat.latch_after = (k == FRAME_LEN - 1);
            bit_queue.push_back(beat);
         end
      endfunction

      function void check_beat(sssf_pkg::rsp_beat_type got, bit [1:0] pad);
         sssf_pkg::rsp_beat_type want;
         beats_seen++;
         if (bit_queue.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR: unexpected result beat %0d: serial=%0b index=%0d last=%0b",
                        beats_seen, got.serial_bit, got.bit_index, got.latch_after);
            return;
         end
         want = bit_queue.pop_front();
         if (got != want || pad != 2'b00) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR: beat %0d: expected %0b/%0d/%0b, got %0b/%0d/%0b pad=%b",
                        beats_seen, want.serial_bit, want.bit_index, want.latch_after,
                        got.serial_bit, got.bit_index, got.latch_after, pad);
         end
      endfunction

      function int pending();
         return bit_queue.size();
      endfunction
   endclass

   frame_scoreboard board = new();

   seven_segment_frame_serializer_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Both channels are sampled at the edge, before any update of that edge lands.
   always @(posedge clock) begin
      sssf_pkg::rsp_beat_type got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_frame(req_tuser, req_tdata[15:0], req_tdata[19:16],
                             req_tdata[21:20], req_tdata[53:22]);
         if (rsp_tvalid && rsp_tready) begin
            got.serial_bit  = rsp_tdata[0];
            got.bit_index   = rsp_tdata[5:1];
            got.latch_after = rsp_tlast;
            board.check_beat(got, rsp_tdata[7:6]);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      int quiet_cycles;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Result-side stalls in random bursts.
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (gaps_on && $urandom_range(0, 11) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offers one frame and holds it until the block accepts the beat.
   task automatic send_frame(input bit func, input bit [15:0] value, input bit [3:0] leds,
                             input bit [1:0] dot, input bit [31:0] raw);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tdata  <= {2'b00, raw, dot, leds, value};
      req_tuser  <= func;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Mostly composed frames; values lean toward three-digit numbers.
   task automatic send_random_frame();
      bit        func;
      bit [15:0] value;
      func = ($urandom_range(0, 9) < 3) ? FUNC_RAW : FUNC_COMPOSE;
      case ($urandom_range(0, 2))
         0:       value = 16'($urandom_range(0, 999));
         1:       value = 16'($urandom_range(0, 65535));
         default: value = 16'($urandom_range(0, 9) * 111 + $urandom_range(0, 1) * 1000);
      endcase
      send_frame(func, value, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                 $urandom);
   endtask

   initial begin
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= FUNC_COMPOSE;
      reset      <= 1'b1;
      gaps_on     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every digit in every place, bar counts in and out of range,
      // each point position, extremes of value and raw frames.
      for (int d = 0; d < 10; d++)
         send_frame(FUNC_COMPOSE, 16'(d * 111), 4'(d), 2'(d % 4), 32'hFFFF_FFFF);
      send_frame(FUNC_COMPOSE, 16'd0, 4'd0, 2'd0, 32'h0);
      send_frame(FUNC_COMPOSE, 16'hFFFF, 4'd15, 2'd3, 32'h0);
      send_frame(FUNC_COMPOSE, 16'd808, 4'd10, 2'd2, 32'h0);
      send_frame(FUNC_COMPOSE, 16'd1000, 4'd12, 2'd1, 32'h5A5A_5A5A);
      send_frame(FUNC_COMPOSE, 16'd987, 4'd11, 2'd3, 32'h0);
      send_frame(FUNC_COMPOSE, 16'd65432, 4'd13, 2'd0, 32'h0);
      send_frame(FUNC_COMPOSE, 16'd1234, 4'd14, 2'd1, 32'h0);
      send_frame(FUNC_RAW, 16'hFFFF, 4'd15, 2'd3, 32'h0000_0000);
      send_frame(FUNC_RAW, 16'd0, 4'd0, 2'd0, 32'hFFFF_FFFF);
      send_frame(FUNC_RAW, 16'd888, 4'd8, 2'd1, 32'hA5A5_A5A5);
      send_frame(FUNC_RAW, 16'd0, 4'd0, 2'd0, 32'h8000_0001);

      // Random frames in chunks, idling on or off per chunk.
      for (int n = 0; n < RANDOM_FRAMES - QUIET_FRAMES; n++) begin
         if (n % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
         send_random_frame();
      end
      // Final stretch back to back on both sides.
      gaps_on = 1'b0;
      for (int n = 0; n < QUIET_FRAMES; n++)
         send_random_frame();
      req_tvalid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (board.failures == 0 && board.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
